[src/stis_pkg.sv]
// shared constants and types for the sparse ternary index sampler
`default_nettype none

package stis_pkg;

  // default vector dimension and bitmap row geometry
  localparam int MAX_DIM_DEF = 2048;
  localparam int ROW_BITS    = 16;
  localparam int ROW_LSB     = 4;

  // field widths
  localparam int WORD_W  = 16;
  localparam int LIMIT_W = 17;
  localparam int DIV_W   = 16;
  localparam int WT_W    = 12;
  localparam int POS_W   = 11;
  localparam int PAIR_W  = 10;
  localparam int CFG_W   = 17;
  localparam int CFG_IW  = 2;
  localparam int STEP_W  = 4;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_REJECT_LIMIT  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_INDEX_DIVISOR = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_WEIGHT        = 2'd2;

  // reset values of the configuration registers
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 17'd65508;
  localparam logic [DIV_W-1:0]   DIV_RST   = 16'd106;
  localparam logic [WT_W-1:0]    WT_RST    = 12'd104;

  typedef logic [ROW_BITS-1:0] row_t;

endpackage

`default_nettype wire

[src/sparse_ternary_index_sampler_top.sv]
// top level of the sparse ternary index sampler
//
// Usage: random 16-bit words come in on the in_ channel (in_valid/in_stall),
// accepted distinct positions leave on the out_ channel (out_valid/out_stall)
// with their pair number, sign and a last flag on the final position of a
// vector. Registers reject_limit, index_divisor and weight are written over
// the cfg_ port; the user must write them only while the block is idle,
// which the block itself does not enforce.
// Flow: a word at or above the limit, or any word while the divisor is
// zero, is dropped in its transfer cycle. Any other word holds the input
// through the bit-serial quotient, the bitmap read and the check and write
// back; the next word is taken only once the block is back in idle. The
// bitmap is a memory of 16-bit rows, at most one read-modify-write per word.
// Reset: synchronous, active low; registers take their reset values, the
// count is zero and every bitmap row reads as clear (one valid flag per row,
// no clearing pass). The flags are also dropped at the end of each vector.
// Stall: one result is held in the output register; a word may be taken and
// divided meanwhile, and the block waits at the check step until that
// register frees up.
`default_nettype none

module sparse_ternary_index_sampler_top
  import stis_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WORD_W-1:0] in_random_word,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [POS_W-1:0]       out_position,
  output logic [PAIR_W-1:0]      out_pair_number,
  output logic                   out_is_subtract,
  output logic                   out_last,
  // configuration port
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  localparam int ROWS  = (MAX_DIM + ROW_BITS - 1) / ROW_BITS;
  localparam int RAW   = $clog2(ROWS);
  localparam int EWT_W = $clog2(MAX_DIM) + 1;
  localparam logic [EWT_W-1:0] MAX_DIM_E = EWT_W'(MAX_DIM);
  localparam logic [WORD_W:0]  MAX_DIM_Q = (WORD_W+1)'(MAX_DIM);

  // state codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_CHK  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [LIMIT_W-1:0]  limit_r;
  logic [DIV_W-1:0]    divisor_r;
  logic [WT_W-1:0]     weight_r;
  logic [WT_W-1:0]     cnt_r, cnt_nxt;
  logic [ROWS-1:0]     row_vld_r, row_vld_nxt;
  logic [WORD_W-1:0]   quo_r, quo_nxt;
  logic [DIV_W-1:0]    rem_r, rem_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]    pos_r;
  logic [PAIR_W-1:0]   pair_r;
  logic                sub_r;
  logic                last_r;
  logic                load_out;

  logic                in_xfer;
  logic                word_ok;
  logic [DIV_W:0]      trial;
  logic [RAW-1:0]      row_addr;
  logic [ROW_LSB-1:0]  bit_sel;
  row_t                ram_rdata;
  row_t                row_cur;
  row_t                row_new;
  logic                ram_we;
  logic                ram_re;
  logic                in_range;
  logic                hit;
  logic                slot_free;
  logic [WT_W-1:0]     cnt_inc;
  logic [EWT_W-1:0]    eff_wt;
  logic                vec_end;

  assign in_stall        = (state_r != ST_IDLE);
  assign in_xfer         = in_valid && !in_stall;
  assign out_valid       = out_valid_r;
  assign out_position    = pos_r;
  assign out_pair_number = pair_r;
  assign out_is_subtract = sub_r;
  assign out_last        = last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= LIMIT_RST;
      divisor_r <= DIV_RST;
      weight_r  <= WT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_REJECT_LIMIT:  limit_r   <= cfg_wdata[LIMIT_W-1:0];
        CFG_INDEX_DIVISOR: divisor_r <= cfg_wdata[DIV_W-1:0];
        CFG_WEIGHT:        weight_r  <= cfg_wdata[WT_W-1:0];
        default:           ;
      endcase
    end
  end

  // limit test and zero divisor drop the word at once
  assign word_ok = ({1'b0, in_random_word} < limit_r) && (divisor_r != '0);

  // one restoring divide step
  assign trial = {rem_r, quo_r[WORD_W-1]} - {1'b0, divisor_r};

  // bitmap row lookup
  assign row_addr = quo_r[ROW_LSB +: RAW];
  assign bit_sel  = quo_r[ROW_LSB-1:0];
  assign row_cur  = row_vld_r[row_addr] ? ram_rdata : '0;
  assign in_range = ({1'b0, quo_r} < MAX_DIM_Q);
  assign hit      = row_cur[bit_sel];
  always_comb begin
    row_new          = row_cur;
    row_new[bit_sel] = 1'b1;
  end

  // effective weight: zero acts as one, saturated at the dimension
  always_comb begin
    if (weight_r == '0) begin
      eff_wt = EWT_W'(1);
    end else if ({{(EWT_W > WT_W ? EWT_W - WT_W : 0){1'b0}}, weight_r} > MAX_DIM_E) begin
      eff_wt = MAX_DIM_E;
    end else begin
      eff_wt = EWT_W'(weight_r);
    end
  end
  assign cnt_inc   = cnt_r + 1'b1;
  assign vec_end   = ({1'b0, cnt_inc} >= (WT_W+1)'(eff_wt));
  assign slot_free = !out_valid_r || !out_stall;

  // control and datapath next state
  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    row_vld_nxt   = row_vld_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    load_out      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && word_ok) begin
          quo_nxt   = in_random_word;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!trial[DIV_W]) begin
          rem_nxt = trial[DIV_W-1:0];
        end else begin
          rem_nxt = {rem_r[DIV_W-2:0], quo_r[WORD_W-1]};
        end
        quo_nxt  = {quo_r[WORD_W-2:0], !trial[DIV_W]};
        step_nxt = step_r + 1'b1;
        if (step_r == '1) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (!in_range || hit) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          ram_we                = 1'b1;
          load_out              = 1'b1;
          out_valid_nxt         = 1'b1;
          row_vld_nxt[row_addr] = 1'b1;
          cnt_nxt               = cnt_inc;
          if (vec_end) begin
            row_vld_nxt = '0;
            cnt_nxt     = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // divider and result payload registers
  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (load_out) begin
      pos_r  <= quo_r[POS_W-1:0];
      pair_r <= cnt_r[PAIR_W:1];
      sub_r  <= cnt_r[0];
      last_r <= vec_end;
    end
  end

  // used-position bitmap, one row of positions per entry
  stis_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_addr),
    .wdata (row_new),
    .re    (ram_re),
    .raddr (row_addr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

[src/stis_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module stis_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
